// ----- rtl/aes_lte_pkg.sv -----
// Package with command codes and GF(2^8) helper functions for the AES lookup word block.
package aes_lte_pkg;

  // Table kinds carried in the command field.
  localparam logic [1:0] CMD_FWD_ROUND = 2'd0;
  localparam logic [1:0] CMD_FWD_LAST  = 2'd1;
  localparam logic [1:0] CMD_INV_ROUND = 2'd2;
  localparam logic [1:0] CMD_INV_LAST  = 2'd3;

  // Low byte of the reduction polynomial x^8+x^4+x^3+x+1.
  localparam logic [7:0] GF_POLY_LOW   = 8'h1b;
  // Constants of the forward and inverse affine transforms.
  localparam logic [7:0] AFF_FWD_CONST = 8'h63;
  localparam logic [7:0] AFF_INV_CONST = 8'h05;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  typedef logic [7:0] gf_byte_t;

  // Multiply by x with reduction.
  function automatic gf_byte_t gf_xtime(input gf_byte_t a);
    gf_byte_t r;
    r = {a[6:0], 1'b0};
    if (a[7]) begin
      r = r ^ GF_POLY_LOW;
    end
    return r;
  endfunction

  // Shift-and-add field multiply; eight narrow steps.
  function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
    gf_byte_t acc;
    gf_byte_t sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ sh;
      end
      sh = gf_xtime(sh);
    end
    return acc;
  endfunction

  // Field squaring.
  function automatic gf_byte_t gf_sq(input gf_byte_t a);
    return gf_mul(a, a);
  endfunction

  // Field inverse as a^254 through a short addition chain; zero maps to zero.
  function automatic gf_byte_t gf_inv(input gf_byte_t a);
    gf_byte_t a2;
    gf_byte_t a3;
    gf_byte_t a12;
    gf_byte_t a15;
    gf_byte_t a240;
    gf_byte_t a252;
    a2   = gf_sq(a);
    a3   = gf_mul(a2, a);
    a12  = gf_sq(gf_sq(a3));
    a15  = gf_mul(a12, a3);
    a240 = gf_sq(gf_sq(gf_sq(gf_sq(a15))));
    a252 = gf_mul(a240, a12);
    return gf_mul(a252, a2);
  endfunction

  // Rotate a byte left.
  function automatic gf_byte_t rotl8(input gf_byte_t x, input int unsigned n);
    return gf_byte_t'((x << n) | (x >> (8 - n)));
  endfunction

  // Forward S-box: inverse followed by the affine transform.
  function automatic gf_byte_t sbox_fwd(input gf_byte_t x);
    gf_byte_t b;
    b = gf_inv(x);
    return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ AFF_FWD_CONST;
  endfunction

  // Inverse S-box: undo the affine transform, then invert.
  function automatic gf_byte_t sbox_inv(input gf_byte_t x);
    gf_byte_t b;
    b = rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ AFF_INV_CONST;
    return gf_inv(b);
  endfunction

endpackage

// ----- rtl/aes_lookup_table_entry_core.sv -----
// Top level of the AES lookup word block: input register, lookup logic and result register.
// One word in, one 32-bit lookup word out. A word is held in an input register, passes the
// S-box and MixColumns-multiple logic combinationally and lands in the result register, and
// the block takes a new word every cycle while the output side keeps up. The lookup is
// computed in GF(2^8) logic rather than read from stored tables; there is no state and no
// configuration.
module aes_lookup_table_entry_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [aes_lte_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] byte_index, [9:8] rotation,
                                                         // [15:10] zero
  input  logic [aes_lte_pkg::IN_USER_W-1:0]  in_tuser,   // [1:0] command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [aes_lte_pkg::OUT_DATA_W-1:0] out_tdata   // [31:0] table_word
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [1:0]  s1_command_r;
  logic [7:0]  s1_index_r;
  logic [1:0]  s1_rotation_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_word_r;
  logic [31:0] word;
  logic        s2_load;
  logic        in_accept;

  // Pipeline advance: the result register loads when empty or being drained.
  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign in_accept = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s2_load);
  assign out_valid_nxt = s2_load || (out_valid_r && !out_tready);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_command_r  <= in_tuser;
      s1_index_r    <= in_tdata[7:0];
      s1_rotation_r <= in_tdata[9:8];
    end
  end

  // Lookup logic.
  aes_lte_word u_word (
    .command    (s1_command_r),
    .byte_index (s1_index_r),
    .rotation   (s1_rotation_r),
    .table_word (word)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_word_r <= word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

`ifndef SYNTHESIS
  // A held input word stays until it moves on.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_load) |=> s1_valid_r)
    else $error("input register lost a word");

  // The result register takes exactly the computed word.
  a_out_word: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> (out_tvalid && out_tdata == $past(word)))
    else $error("result register does not match lookup");

  // Input is refused only with both stages full and the output stalled.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without cause");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !s1_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- rtl/aes_lte_word.sv -----
// Combinational lookup word: S-box value, MixColumns multiples and byte rotation.
module aes_lte_word (
  input  logic [1:0]  command,
  input  logic [7:0]  byte_index,
  input  logic [1:0]  rotation,
  output logic [31:0] table_word
);

  aes_lte_pkg::gf_byte_t s_fwd;
  aes_lte_pkg::gf_byte_t s_inv;
  logic [31:0]           word;

  // Both S-box directions; the command picks one.
  assign s_fwd = aes_lte_pkg::sbox_fwd(byte_index);
  assign s_inv = aes_lte_pkg::sbox_inv(byte_index);

  // Assemble the unrotated word, least significant byte first.
  always_comb begin
    unique case (command)
      aes_lte_pkg::CMD_FWD_ROUND: begin
        word = {aes_lte_pkg::gf_mul(8'd3, s_fwd), s_fwd, s_fwd,
                aes_lte_pkg::gf_mul(8'd2, s_fwd)};
      end
      aes_lte_pkg::CMD_FWD_LAST: begin
        word = {24'd0, s_fwd};
      end
      aes_lte_pkg::CMD_INV_ROUND: begin
        word = {aes_lte_pkg::gf_mul(8'd11, s_inv), aes_lte_pkg::gf_mul(8'd13, s_inv),
                aes_lte_pkg::gf_mul(8'd9, s_inv), aes_lte_pkg::gf_mul(8'd14, s_inv)};
      end
      default: begin
        word = {24'd0, s_inv};
      end
    endcase
  end

  // Rotate left by whole bytes.
  always_comb begin
    unique case (rotation)
      2'd0:    table_word = word;
      2'd1:    table_word = {word[23:0], word[31:24]};
      2'd2:    table_word = {word[15:0], word[31:16]};
      default: table_word = {word[7:0], word[31:8]};
    endcase
  end

endmodule

// ----- tb/sv/aes_lookup_table_entry_checker.sv -----
// Checker for the AES lookup word block: predicts each lookup word and compares the results.
`timescale 1ns / 100ps

module aes_lookup_table_entry_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,    // [7:0] byte_index, [9:8] rotation, [15:10] zero
  input  logic [1:0]  in_tuser,    // [1:0] command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,   // [31:0] table_word
  output int          mismatch_count,
  output int          pending_words
);

  localparam logic [7:0] REDUCE_BYTE = 8'h1b;
  localparam logic [7:0] SUBST_CONST = 8'h63;
  localparam logic [7:0] UNDO_CONST  = 8'h05;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [1:0]  turns;
    logic [31:0] word;
  } lookup_t;

  lookup_t lookup_words[$];

  // Multiply by x, folding the carry back with the reduction byte.
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? REDUCE_BYTE : 8'h00);
  endfunction

  function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] term;
    acc  = 8'h00;
    term = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc ^= term;
      end
      term = gf_double(term);
    end
    return acc;
  endfunction

  // Raise to the power 254 by square and multiply; zero stays zero.
  function automatic logic [7:0] gf_reciprocal(input logic [7:0] a);
    logic [7:0] acc;
    logic [7:0] pw;
    logic [7:0] expo;
    acc  = 8'h01;
    pw   = a;
    expo = 8'd254;
    for (int i = 0; i < 8; i++) begin
      if (expo[i]) begin
        acc = gf_product(acc, pw);
      end
      pw = gf_product(pw, pw);
    end
    return acc;
  endfunction

  function automatic logic [7:0] byte_rotl(input logic [7:0] x, input int n);
    logic [15:0] twice;
    twice = {x, x} << n;
    return twice[15:8];
  endfunction

  function automatic logic [7:0] fwd_subst(input logic [7:0] x);
    logic [7:0] r;
    r = gf_reciprocal(x);
    return r ^ byte_rotl(r, 1) ^ byte_rotl(r, 2) ^ byte_rotl(r, 3) ^ byte_rotl(r, 4)
           ^ SUBST_CONST;
  endfunction

  function automatic logic [7:0] inv_subst(input logic [7:0] x);
    return gf_reciprocal(byte_rotl(x, 1) ^ byte_rotl(x, 3) ^ byte_rotl(x, 6) ^ UNDO_CONST);
  endfunction

  // Builds the table word for one request and rotates it left by whole bytes.
  function automatic logic [31:0] lookup_word(input logic [1:0] kind, input logic [7:0] index,
                                              input logic [1:0] turns);
    logic [7:0]  s;
    logic [31:0] w;
    logic [63:0] twice;
    case (kind)
      aes_lte_pkg::CMD_FWD_ROUND: begin
        s = fwd_subst(index);
        w = {gf_product(8'd3, s), s, s, gf_product(8'd2, s)};
      end
      aes_lte_pkg::CMD_FWD_LAST: begin
        w = {24'h0, fwd_subst(index)};
      end
      aes_lte_pkg::CMD_INV_ROUND: begin
        s = inv_subst(index);
        w = {gf_product(8'd11, s), gf_product(8'd13, s), gf_product(8'd9, s),
             gf_product(8'd14, s)};
      end
      default: begin
        w = {24'h0, inv_subst(index)};
      end
    endcase
    twice = {w, w} << (8 * turns);
    return twice[63:32];
  endfunction

  initial begin
    mismatch_count = 0;
    pending_words  = 0;
  end

  // Compare each delivered word with the oldest prediction, then record new requests.
  always @(posedge clk) begin
    lookup_t req;
    lookup_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (lookup_words.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: word 0x%08h delivered with no request outstanding",
                     $realtime, out_tdata);
          end
          mismatch_count++;
        end else begin
          want = lookup_words.pop_front();
          if (out_tdata !== want.word) begin
            if (mismatch_count < 10) begin
              $display("%0t: kind %0d index 0x%02h rotation %0d: expected 0x%08h, got 0x%08h",
                       $realtime, want.kind, want.index, want.turns, want.word, out_tdata);
            end
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        req.kind  = in_tuser;
        req.index = in_tdata[7:0];
        req.turns = in_tdata[9:8];
        req.word  = lookup_word(req.kind, req.index, req.turns);
        lookup_words.push_back(req);
      end
      pending_words = lookup_words.size();
    end
  end

endmodule

// ----- tb/sv/aes_lookup_table_entry_core_tb.sv -----
// Testbench top for the AES lookup word block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module aes_lookup_table_entry_core_tb;

  localparam int RANDOM_WORDS = 1750;
  localparam int CALM_WORDS   = 250;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  int mismatch_count;
  int pending_words;
  int cycle_count;
  bit calm;

  aes_lookup_table_entry_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  aes_lookup_table_entry_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one request word and hold it until the block takes it.
  task automatic send_word(input logic [1:0] kind, input logic [7:0] index,
                           input logic [1:0] turns);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, turns, index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid for a while; the data lines carry junk meanwhile.
  task automatic idle_input(input int cycles);
    in_tvalid <= 1'b0;
    in_tdata  <= 16'($urandom);
    in_tuser  <= 2'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Result side: random stall bursts in busy phases, always ready in the calm tail.
  initial begin
    int stretch;
    bit busy;
    out_tready <= 1'b0;
    busy    = 1'b1;
    stretch = 0;
    forever begin
      @(posedge clk);
      if (stretch == 0) begin
        busy    = ($urandom_range(0, 2) != 0);
        stretch = $urandom_range(50, 300);
      end
      stretch--;
      if (!calm && busy && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [1:0] kinds[4];
    int stretch;
    bit busy;
    kinds = '{aes_lte_pkg::CMD_FWD_ROUND, aes_lte_pkg::CMD_FWD_LAST,
              aes_lte_pkg::CMD_INV_ROUND, aes_lte_pkg::CMD_INV_LAST};
    calm      = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: index extremes and the zero byte in both directions, all rotations.
    // Index 0x63 maps back to the zero byte through the inverse table.
    foreach (kinds[k]) begin
      send_word(kinds[k], 8'h00, 2'd0);
      send_word(kinds[k], 8'hff, 2'd3);
      send_word(kinds[k], 8'h01, 2'd1);
      send_word(kinds[k], 8'h80, 2'd2);
      send_word(kinds[k], 8'h63, 2'd0);
      idle_input(2);
      send_word(kinds[k], 8'h52, 2'(k));
    end
    idle_input(1);
    wait_drained();

    // Random part, with busy and quiet sender phases.
    busy    = 1'b1;
    stretch = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_WORDS) begin
        calm = 1'b1;
      end
      if (n == RANDOM_WORDS / 3) begin
        idle_input(1);
        wait_drained();
      end
      if (stretch == 0) begin
        busy    = ($urandom_range(0, 2) != 0);
        stretch = $urandom_range(40, 200);
      end
      stretch--;
      if (!calm && busy && $urandom_range(0, 6) == 0) begin
        idle_input($urandom_range(1, 16));
      end
      send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                2'($urandom_range(0, 3)));
    end
    in_tvalid <= 1'b0;

    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && pending_words == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
